>>> rtl/bfs_pkg.sv
// Shared types and constants of the boid flocking steering unit.
package bfs_pkg;

  // Records of one run beyond this count are ignored; counters are 9 bits wide.
  localparam int unsigned MAX_NEIGHBORS = 256;

  localparam logic [15:0] RST_MAX_SPEED = 16'd512;
  localparam logic [15:0] RST_MAX_FORCE = 16'd8;
  localparam logic [11:0] RST_SEP_W     = 12'd384;
  localparam logic [11:0] RST_ALI_W     = 12'd256;
  localparam logic [11:0] RST_COH_W     = 12'd256;
  localparam logic [7:0]  RST_SEP_RAD   = 8'd25;
  localparam logic [7:0]  RST_NBR_RAD   = 8'd50;

  typedef enum logic [2:0] {
    CFG_MAX_SPEED = 3'd0,
    CFG_MAX_FORCE = 3'd1,
    CFG_SEP_W     = 3'd2,
    CFG_ALI_W     = 3'd3,
    CFG_COH_W     = 3'd4,
    CFG_SEP_RAD   = 3'd5,
    CFG_NBR_RAD   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } iter_op_e;

  typedef struct packed {
    logic        start;
    iter_op_e    op;
    logic [45:0] num;
    logic [30:0] den;
    logic [60:0] rad;
  } iter_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [30:0] res;
  } iter_rsp_t;

  typedef enum logic [1:0] {
    FRC_SEP,
    FRC_ALI,
    FRC_COH
  } frc_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_D2,
    ST_CMP,
    ST_DIVX,
    ST_DIVY,
    ST_TAIL,
    ST_FSEL,
    ST_CMULX,
    ST_CMULY,
    ST_CVEC,
    ST_NSTART,
    ST_NORM,
    ST_NSQX,
    ST_NSQY,
    ST_NSUM,
    ST_NROOT,
    ST_NDIVX,
    ST_NWAITX,
    ST_NDIVY,
    ST_NWAITY,
    ST_LIM0,
    ST_LIM1,
    ST_LIM2,
    ST_LIM3,
    ST_FSTORE,
    ST_WMUL,
    ST_WACC,
    ST_OUT
  } st_e;

endpackage

>>> rtl/bfs_iter.sv
// Shared multi-cycle unit: restoring divider and digit-by-digit square root.
module bfs_iter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfs_pkg::iter_cmd_t    cmd_i,
  output bfs_pkg::iter_rsp_t    rsp_o
);
  import bfs_pkg::*;

  iter_op_e    op_q;
  logic [4:0]  cnt_q;
  logic [30:0] den_q;
  logic [30:0] rem_q;
  logic [28:0] num_q;
  logic [62:0] rad_q;
  logic [61:0] res_q;
  logic [61:0] bit_q;
  logic [31:0] rem_sh;
  logic [62:0] trial;

  assign rem_sh = {rem_q, num_q[28]};
  assign trial  = {1'b0, res_q} + {1'b0, bit_q};

  // iteration count: 29 quotient bits or 31 root bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= (cmd_i.op == OP_DIV) ? 5'd29 : 5'd31;
    end else if (cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      den_q <= cmd_i.den;
      res_q <= '0;
      rem_q <= {14'd0, cmd_i.num[45:29]};
      num_q <= cmd_i.num[28:0];
      rad_q <= {2'b00, cmd_i.rad};
      bit_q <= {2'b00, 1'b1, 59'd0} << 1;
    end else if (cnt_q != 5'd0) begin
      unique case (op_q)
        OP_DIV: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= 31'(rem_sh - {1'b0, den_q});
            res_q <= {res_q[60:0], 1'b1};
          end else begin
            rem_q <= rem_sh[30:0];
            res_q <= {res_q[60:0], 1'b0};
          end
          num_q <= {num_q[27:0], 1'b0};
        end
        OP_SQRT: begin
          if (rad_q >= trial) begin
            rad_q <= rad_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        default: begin
          res_q <= res_q;
        end
      endcase
    end
  end

  assign rsp_o.busy = (cnt_q != 5'd0);
  assign rsp_o.res  = res_q[30:0];

endmodule

>>> rtl/boid_flocking_steering_unit.sv
// Top level of the boid flocking steering unit (separation, alignment, cohesion).
//
// One boid's flocking force is built from a run of neighbour records, one record per
// item; the item flagged last closes the run and yields one result (force_x/force_y in
// signed Q8.8, saturated, plus the close and near counts). All multiplications go
// through one 33x33 multiplier with a registered product, and divisions and square
// roots through one shared iterative unit. The unit stalls its input for the whole of
// each item; a record whose neighbour lies inside the separation radius adds two
// divisions of the offset by the squared distance. A last record adds the final
// phase: up to six vector normalizations (one shift per cycle to bring the vector
// into range, the square root, two divisions) plus the weighting. A finished result
// sits in an output register, so the next run may start while it waits; a further
// result waits until the previous one is taken. Records past the first 256 of a run
// are ignored, but a last flag still closes the run.
// Configuration writes are taken any cycle and must only be made while idle.
module boid_flocking_steering_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // record channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] self_x_i,
  input  logic [15:0] self_y_i,
  input  logic [15:0] self_vx_i,
  input  logic [15:0] self_vy_i,
  input  logic [15:0] nbr_x_i,
  input  logic [15:0] nbr_y_i,
  input  logic [15:0] nbr_vx_i,
  input  logic [15:0] nbr_vy_i,
  input  logic        last_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] force_x_o,
  output logic [15:0] force_y_o,
  output logic [8:0]  close_count_o,
  output logic [8:0]  near_count_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import bfs_pkg::*;

  // configuration registers
  logic [15:0] max_speed_q, max_force_q;
  logic [11:0] sep_w_q, ali_w_q, coh_w_q;
  logic [7:0]  sep_rad_q, nbr_rad_q;

  // captured record
  logic signed [15:0] sx_q, sy_q, svx_q, svy_q, nx_q, ny_q, nvx_q, nvy_q;
  logic               last_q;

  // run accumulators
  logic [8:0]         rec_q, close_q, near_q;
  logic signed [39:0] rep_x_q, rep_y_q;
  logic signed [24:0] head_x_q, head_y_q, cen_x_q, cen_y_q;

  // sequencer
  st_e  st_q, st_d;
  frc_e frc_q;
  logic lim_q;
  logic [2:0] w_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] p_q;

  // working registers
  logic [63:0]        sq_q;
  logic [33:0]        d2_q;
  logic signed [40:0] vin_x_q, vin_y_q;
  logic [40:0]        mx_q, my_q;
  logic [30:0]        root_q;
  logic signed [17:0] res_x_q, res_y_q;
  logic signed [18:0] ex_q, ey_q;
  logic signed [17:0] fsx_q, fsy_q, fax_q, fay_q, fcx_q, fcy_q;
  logic signed [33:0] wacc_q, tx_q;

  // output register
  logic        out_valid_q;
  logic [15:0] force_x_q, force_y_q;
  logic [8:0]  close_out_q, near_out_q;

  iter_cmd_t cmd;
  iter_rsp_t rsp;

  // combinational helpers
  logic signed [16:0] dx, dy;
  logic [15:0]        adx, ady;
  logic [15:0]        rs_sq, rn_sq;
  logic               close_hit, near_hit;
  logic [15:0]        len;
  logic [40:0]        mmax;
  logic signed [18:0] ex, ey;
  logic signed [39:0] tq;
  logic signed [17:0] qs;
  logic signed [33:0] wsum;
  logic               out_go;

  assign dx  = 17'(sx_q) - 17'(nx_q);
  assign dy  = 17'(sy_q) - 17'(ny_q);
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];

  // radius r pixels is r*16 in Q.4, squared r*r*256
  assign rs_sq     = 16'(sep_rad_q * sep_rad_q);
  assign rn_sq     = 16'(nbr_rad_q * nbr_rad_q);
  assign close_hit = (d2_q != '0) && (d2_q < {10'd0, rs_sq, 8'd0});
  assign near_hit  = (d2_q != '0) && (d2_q < {10'd0, rn_sq, 8'd0});

  assign len  = lim_q ? max_force_q : max_speed_q;
  assign mmax = (mx_q > my_q) ? mx_q : my_q;
  assign ex   = 19'(res_x_q) - 19'(svx_q);
  assign ey   = 19'(res_y_q) - 19'(svy_q);
  assign tq   = $signed({11'd0, rsp.res[28:0]});
  assign qs   = $signed({1'b0, rsp.res[16:0]});
  assign wsum = wacc_q + 34'(p_q);

  assign out_go = !out_valid_q || !out_stall_i;

  assign prod = mul_a * mul_b;

  // truncate toward zero after /256, then saturate to 16 bits
  function automatic logic [15:0] sat_q8(input logic signed [33:0] t);
    logic [33:0] m;
    logic [25:0] s;
    logic [15:0] r;
    m = t[33] ? 34'(-t) : 34'(t);
    s = m[33:8];
    if (t[33]) begin
      r = (s > 26'd32768) ? 16'h8000 : 16'(-s);
    end else begin
      r = (s > 26'd32767) ? 16'h7fff : s[15:0];
    end
    return r;
  endfunction

  bfs_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  // next state, multiplier operands, unit commands
  always_comb begin
    st_d       = st_q;
    mul_a      = '0;
    mul_b      = '0;
    cmd        = '0;
    in_stall_o = 1'b1;
    unique case (st_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          st_d = ST_SQX;
        end
      end
      ST_SQX: begin
        if (rec_q >= 9'(MAX_NEIGHBORS)) begin
          st_d = ST_TAIL;
        end else begin
          mul_a = 33'(dx);
          mul_b = 33'(dx);
          st_d  = ST_SQY;
        end
      end
      ST_SQY: begin
        mul_a = 33'(dy);
        mul_b = 33'(dy);
        st_d  = ST_D2;
      end
      ST_D2: begin
        st_d = ST_CMP;
      end
      ST_CMP: begin
        if (close_hit) begin
          cmd.start = 1'b1;
          cmd.op    = OP_DIV;
          cmd.num   = 46'({adx, 28'd0});
          cmd.den   = d2_q[30:0];
          st_d      = ST_DIVX;
        end else begin
          st_d = ST_TAIL;
        end
      end
      ST_DIVX: begin
        if (!rsp.busy) begin
          cmd.start = 1'b1;
          cmd.op    = OP_DIV;
          cmd.num   = 46'({ady, 28'd0});
          cmd.den   = d2_q[30:0];
          st_d      = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (!rsp.busy) begin
          st_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        st_d = last_q ? ST_FSEL : ST_IDLE;
      end
      ST_FSEL: begin
        unique case (frc_q)
          FRC_SEP: st_d = ((rep_x_q != '0) || (rep_y_q != '0)) ? ST_NSTART : ST_FSTORE;
          FRC_ALI: st_d = (near_q != '0) ? ST_NSTART : ST_FSTORE;
          FRC_COH: st_d = (near_q != '0) ? ST_CMULX : ST_FSTORE;
          default: st_d = ST_FSTORE;
        endcase
      end
      ST_CMULX: begin
        mul_a = 33'(near_q);
        mul_b = 33'(sx_q);
        st_d  = ST_CMULY;
      end
      ST_CMULY: begin
        mul_a = 33'(near_q);
        mul_b = 33'(sy_q);
        st_d  = ST_CVEC;
      end
      ST_CVEC: begin
        st_d = ST_NSTART;
      end
      ST_NSTART: begin
        if ((vin_x_q == '0) && (vin_y_q == '0)) begin
          st_d = lim_q ? ST_FSTORE : ST_LIM0;
        end else begin
          st_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!(|mmax[40:30]) && (|mmax[29])) begin
          st_d = ST_NSQX;
        end
      end
      ST_NSQX: begin
        mul_a = 33'(mx_q[29:0]);
        mul_b = 33'(mx_q[29:0]);
        st_d  = ST_NSQY;
      end
      ST_NSQY: begin
        mul_a = 33'(my_q[29:0]);
        mul_b = 33'(my_q[29:0]);
        st_d  = ST_NSUM;
      end
      ST_NSUM: begin
        cmd.start = 1'b1;
        cmd.op    = OP_SQRT;
        cmd.rad   = 61'(sq_q + $unsigned(p_q));
        st_d      = ST_NROOT;
      end
      ST_NROOT: begin
        if (!rsp.busy) begin
          mul_a = 33'(mx_q[29:0]);
          mul_b = 33'(len);
          st_d  = ST_NDIVX;
        end
      end
      ST_NDIVX: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.num   = p_q[45:0];
        cmd.den   = root_q;
        st_d      = ST_NWAITX;
      end
      ST_NWAITX: begin
        if (!rsp.busy) begin
          mul_a = 33'(my_q[29:0]);
          mul_b = 33'(len);
          st_d  = ST_NDIVY;
        end
      end
      ST_NDIVY: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.num   = p_q[45:0];
        cmd.den   = root_q;
        st_d      = ST_NWAITY;
      end
      ST_NWAITY: begin
        if (!rsp.busy) begin
          st_d = lim_q ? ST_FSTORE : ST_LIM0;
        end
      end
      ST_LIM0: begin
        mul_a = 33'(ex);
        mul_b = 33'(ex);
        st_d  = ST_LIM1;
      end
      ST_LIM1: begin
        mul_a = 33'(ey_q);
        mul_b = 33'(ey_q);
        st_d  = ST_LIM2;
      end
      ST_LIM2: begin
        mul_a = 33'(max_force_q);
        mul_b = 33'(max_force_q);
        st_d  = ST_LIM3;
      end
      ST_LIM3: begin
        st_d = (sq_q > $unsigned(p_q)) ? ST_NSTART : ST_FSTORE;
      end
      ST_FSTORE: begin
        st_d = (frc_q == FRC_COH) ? ST_WMUL : ST_FSEL;
      end
      ST_WMUL: begin
        unique case (w_q)
          3'd0: begin mul_a = 33'(fsx_q); mul_b = 33'(sep_w_q); end
          3'd1: begin mul_a = 33'(fax_q); mul_b = 33'(ali_w_q); end
          3'd2: begin mul_a = 33'(fcx_q); mul_b = 33'(coh_w_q); end
          3'd3: begin mul_a = 33'(fsy_q); mul_b = 33'(sep_w_q); end
          3'd4: begin mul_a = 33'(fay_q); mul_b = 33'(ali_w_q); end
          3'd5: begin mul_a = 33'(fcy_q); mul_b = 33'(coh_w_q); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        st_d = ST_WACC;
      end
      ST_WACC: begin
        st_d = (w_q == 3'd5) ? ST_OUT : ST_WMUL;
      end
      ST_OUT: begin
        if (out_go) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // control state, configuration and run accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      max_speed_q <= RST_MAX_SPEED;
      max_force_q <= RST_MAX_FORCE;
      sep_w_q     <= RST_SEP_W;
      ali_w_q     <= RST_ALI_W;
      coh_w_q     <= RST_COH_W;
      sep_rad_q   <= RST_SEP_RAD;
      nbr_rad_q   <= RST_NBR_RAD;
      out_valid_q <= 1'b0;
      rec_q       <= '0;
      close_q     <= '0;
      near_q      <= '0;
      rep_x_q     <= '0;
      rep_y_q     <= '0;
      head_x_q    <= '0;
      head_y_q    <= '0;
      cen_x_q     <= '0;
      cen_y_q     <= '0;
      frc_q       <= FRC_SEP;
      lim_q       <= 1'b0;
      w_q         <= '0;
    end else begin
      st_q <= st_d;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_SPEED: max_speed_q <= cfg_data_i;
          CFG_MAX_FORCE: max_force_q <= cfg_data_i;
          CFG_SEP_W:     sep_w_q     <= cfg_data_i[11:0];
          CFG_ALI_W:     ali_w_q     <= cfg_data_i[11:0];
          CFG_COH_W:     coh_w_q     <= cfg_data_i[11:0];
          CFG_SEP_RAD:   sep_rad_q   <= cfg_data_i[7:0];
          CFG_NBR_RAD:   nbr_rad_q   <= cfg_data_i[7:0];
          default:       ;
        endcase
      end

      if ((st_q == ST_OUT) && out_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_SQX: begin
          if (rec_q < 9'(MAX_NEIGHBORS)) begin
            rec_q <= rec_q + 9'd1;
          end
        end
        ST_CMP: begin
          if (near_hit) begin
            head_x_q <= head_x_q + 25'(nvx_q);
            head_y_q <= head_y_q + 25'(nvy_q);
            cen_x_q  <= cen_x_q + 25'(nx_q);
            cen_y_q  <= cen_y_q + 25'(ny_q);
            near_q   <= near_q + 9'd1;
          end
          if (close_hit) begin
            close_q <= close_q + 9'd1;
          end
        end
        ST_DIVX: begin
          if (!rsp.busy) begin
            rep_x_q <= dx[16] ? rep_x_q - tq : rep_x_q + tq;
          end
        end
        ST_DIVY: begin
          if (!rsp.busy) begin
            rep_y_q <= dy[16] ? rep_y_q - tq : rep_y_q + tq;
          end
        end
        ST_TAIL: begin
          frc_q <= FRC_SEP;
          lim_q <= 1'b0;
        end
        ST_LIM3: begin
          if (sq_q > $unsigned(p_q)) begin
            lim_q <= 1'b1;
          end
        end
        ST_FSTORE: begin
          lim_q <= 1'b0;
          w_q   <= '0;
          if (frc_q != FRC_COH) begin
            frc_q <= frc_e'(frc_q + 2'd1);
          end
        end
        ST_WACC: begin
          w_q <= w_q + 3'd1;
        end
        ST_OUT: begin
          if (out_go) begin
            rec_q    <= '0;
            close_q  <= '0;
            near_q   <= '0;
            rep_x_q  <= '0;
            rep_y_q  <= '0;
            head_x_q <= '0;
            head_y_q <= '0;
            cen_x_q  <= '0;
            cen_y_q  <= '0;
          end
        end
        default: begin
          w_q <= w_q;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= prod[63:0];

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sx_q   <= self_x_i;
          sy_q   <= self_y_i;
          svx_q  <= self_vx_i;
          svy_q  <= self_vy_i;
          nx_q   <= nbr_x_i;
          ny_q   <= nbr_y_i;
          nvx_q  <= nbr_vx_i;
          nvy_q  <= nbr_vy_i;
          last_q <= last_i;
        end
      end
      ST_SQY: sq_q <= $unsigned(p_q);
      ST_D2:  d2_q <= 34'(sq_q + $unsigned(p_q));
      ST_FSEL: begin
        res_x_q <= '0;
        res_y_q <= '0;
        if (frc_q == FRC_SEP) begin
          vin_x_q <= 41'(rep_x_q);
          vin_y_q <= 41'(rep_y_q);
        end else begin
          vin_x_q <= 41'(head_x_q);
          vin_y_q <= 41'(head_y_q);
        end
      end
      // cohesion offset: centre sum minus count times own position
      ST_CMULY: vin_x_q <= 41'(cen_x_q) - $signed(p_q[40:0]);
      ST_CVEC:  vin_y_q <= 41'(cen_y_q) - $signed(p_q[40:0]);
      ST_NSTART: begin
        mx_q    <= vin_x_q[40] ? 41'(-vin_x_q) : 41'(vin_x_q);
        my_q    <= vin_y_q[40] ? 41'(-vin_y_q) : 41'(vin_y_q);
        res_x_q <= '0;
        res_y_q <= '0;
      end
      // bring the larger magnitude into [2^29, 2^30), one bit a cycle
      ST_NORM: begin
        if (|mmax[40:30]) begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
        end else if (!(|mmax[29])) begin
          mx_q <= mx_q << 1;
          my_q <= my_q << 1;
        end
      end
      ST_NSQY: sq_q <= $unsigned(p_q);
      ST_NROOT: begin
        if (!rsp.busy) begin
          root_q <= rsp.res;
        end
      end
      ST_NWAITX: begin
        if (!rsp.busy) begin
          res_x_q <= vin_x_q[40] ? -qs : qs;
        end
      end
      ST_NWAITY: begin
        if (!rsp.busy) begin
          res_y_q <= vin_y_q[40] ? -qs : qs;
        end
      end
      ST_LIM0: begin
        ex_q <= ex;
        ey_q <= ey;
      end
      ST_LIM1: sq_q <= $unsigned(p_q);
      ST_LIM2: sq_q <= sq_q + $unsigned(p_q);
      ST_LIM3: begin
        if (sq_q > $unsigned(p_q)) begin
          vin_x_q <= 41'(ex_q);
          vin_y_q <= 41'(ey_q);
        end else begin
          res_x_q <= ex_q[17:0];
          res_y_q <= ey_q[17:0];
        end
      end
      ST_FSTORE: begin
        wacc_q <= '0;
        unique case (frc_q)
          FRC_SEP: begin fsx_q <= res_x_q; fsy_q <= res_y_q; end
          FRC_ALI: begin fax_q <= res_x_q; fay_q <= res_y_q; end
          FRC_COH: begin fcx_q <= res_x_q; fcy_q <= res_y_q; end
          default: begin fcx_q <= res_x_q; fcy_q <= res_y_q; end
        endcase
      end
      ST_WACC: begin
        if (w_q == 3'd2) begin
          tx_q   <= wsum;
          wacc_q <= '0;
        end else begin
          wacc_q <= wsum;
        end
      end
      ST_OUT: begin
        if (out_go) begin
          force_x_q   <= sat_q8(tx_q);
          force_y_q   <= sat_q8(wacc_q);
          close_out_q <= close_q;
          near_out_q  <= near_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign force_x_o     = force_x_q;
  assign force_y_o     = force_y_q;
  assign close_count_o = close_out_q;
  assign near_count_o  = near_out_q;

endmodule

>>> rtl/bfs_chk.sv
// Port-level checks of the boid flocking steering unit, bound to the top level.
module bfs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] force_x_o,
  input logic [8:0]  close_count_o,
  input logic [8:0]  near_count_o
);
  import bfs_pkg::*;

  // one item at a time: busy right after an accepted record
  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted item");

  // a result is loaded only from the final phase, never while idle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // counts cannot exceed the neighbour limit of a run
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((close_count_o <= 9'(MAX_NEIGHBORS)) &&
                     (near_count_o <= 9'(MAX_NEIGHBORS))))
    else $error("count beyond neighbour limit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(force_x_o))
    else $error("result changed while stalled");

endmodule

bind boid_flocking_steering_unit bfs_chk u_bfs_chk (.*);

>>> test/tb_top.sv
// Testbench for the boid flocking steering unit: directed records and random neighbor runs checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import bfs_pkg::*;

  typedef struct {
    logic signed [15:0] sx, sy, svx, svy, nx, ny, nvx, nvy;
    logic               last;
  } rec_t;

  typedef struct packed {
    logic [15:0] fx, fy;
    logic [8:0]  close_n, near_n;
  } steer_t;

  // Flock force predictor and pending-result store.
  class flock_scoreboard;
    longint unsigned max_speed, max_force, sep_w, ali_w, coh_w, sep_rad, nbr_rad;
    longint repel_x, repel_y, head_x, head_y, ctr_x, ctr_y;
    int unsigned repel_n, near_n, rec_n;
    steer_t pending[$];
    int unsigned errors;

    function new();
      max_speed = RST_MAX_SPEED; max_force = RST_MAX_FORCE;
      sep_w = RST_SEP_W; ali_w = RST_ALI_W; coh_w = RST_COH_W;
      sep_rad = RST_SEP_RAD; nbr_rad = RST_NBR_RAD;
      errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      repel_x = 0; repel_y = 0; head_x = 0; head_y = 0; ctr_x = 0; ctr_y = 0;
      repel_n = 0; near_n = 0; rec_n = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_MAX_SPEED: max_speed = val;
        CFG_MAX_FORCE: max_force = val;
        CFG_SEP_W:     sep_w = val[11:0];
        CFG_ALI_W:     ali_w = val[11:0];
        CFG_COH_W:     coh_w = val[11:0];
        CFG_SEP_RAD:   sep_rad = val[7:0];
        CFG_NBR_RAD:   nbr_rad = val[7:0];
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    // Scale vector to length len; zero stays zero.
    function void scale_to(longint vx, longint vy, longint unsigned len,
                           output longint ox, output longint oy);
      longint unsigned mx, my, m, r, qx, qy;
      mx = mag(vx); my = mag(vy);
      if (mx == 0 && my == 0) begin
        ox = 0; oy = 0;
        return;
      end
      m = mx > my ? mx : my;
      while (m >= (64'd1 << 30)) begin mx >>= 1; my >>= 1; m >>= 1; end
      while (m < (64'd1 << 29)) begin mx <<= 1; my <<= 1; m <<= 1; end
      r = int_sqrt(mx * mx + my * my);
      qx = mx * len / r;
      qy = my * len / r;
      ox = vx < 0 ? -longint'(qx) : longint'(qx);
      oy = vy < 0 ? -longint'(qy) : longint'(qy);
    endfunction

    function void seek(longint dx, longint dy, longint vx, longint vy,
                       output longint ox, output longint oy);
      longint ex, ey;
      scale_to(dx, dy, max_speed, ex, ey);
      ex -= vx;
      ey -= vy;
      if (longint'(ex * ex + ey * ey) > longint'(max_force * max_force))
        scale_to(ex, ey, max_force, ex, ey);
      ox = ex; oy = ey;
    endfunction

    function logic [15:0] blend(longint s, longint a, longint c);
      longint t, q;
      t = s * longint'(sep_w) + a * longint'(ali_w) + c * longint'(coh_w);
      q = t < 0 ? -longint'(mag(t) >> 8) : longint'(mag(t) >> 8);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_record(rec_t r);
      longint dx, dy, fsx, fsy, fax, fay, fcx, fcy;
      longint unsigned d2, rs, rn, tx, ty;
      steer_t res;
      fsx = 0; fsy = 0; fax = 0; fay = 0; fcx = 0; fcy = 0;
      if (rec_n < MAX_NEIGHBORS) begin
        dx = longint'(r.sx) - longint'(r.nx);
        dy = longint'(r.sy) - longint'(r.ny);
        d2 = dx * dx + dy * dy;
        rs = sep_rad * 16;
        rn = nbr_rad * 16;
        rec_n++;
        if (d2 != 0) begin
          if (d2 < rs * rs) begin
            tx = (mag(dx) << 28) / d2;
            ty = (mag(dy) << 28) / d2;
            repel_x += dx < 0 ? -longint'(tx) : longint'(tx);
            repel_y += dy < 0 ? -longint'(ty) : longint'(ty);
            repel_n++;
          end
          if (d2 < rn * rn) begin
            head_x += r.nvx; head_y += r.nvy;
            ctr_x += r.nx;   ctr_y += r.ny;
            near_n++;
          end
        end
      end
      if (!r.last) return;
      if (repel_x != 0 || repel_y != 0) seek(repel_x, repel_y, r.svx, r.svy, fsx, fsy);
      if (near_n > 0) begin
        seek(head_x, head_y, r.svx, r.svy, fax, fay);
        seek(ctr_x - longint'(near_n) * r.sx, ctr_y - longint'(near_n) * r.sy,
             r.svx, r.svy, fcx, fcy);
      end
      res.fx = blend(fsx, fax, fcx);
      res.fy = blend(fsy, fay, fcy);
      res.close_n = repel_n > 511 ? 9'd511 : repel_n[8:0];
      res.near_n = near_n > 511 ? 9'd511 : near_n[8:0];
      pending.push_back(res);
      clear_run();
    endfunction

    function void check_result(steer_t got);
      steer_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result fx=%h fy=%h", got.fx, got.fy);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp fx=%h fy=%h close=%0d near=%0d,",
                   exp_r.fx, exp_r.fy, exp_r.close_n, exp_r.near_n,
                   " got fx=%h fy=%h close=%0d near=%0d",
                   got.fx, got.fy, got.close_n, got.near_n);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, last_i;
  logic [15:0] self_x_i, self_y_i, self_vx_i, self_vy_i;
  logic [15:0] nbr_x_i, nbr_y_i, nbr_vx_i, nbr_vy_i;
  logic        out_valid_o, out_stall_i;
  logic [15:0] force_x_o, force_y_o;
  logic [8:0]  close_count_o, near_count_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  boid_flocking_steering_unit dut (.*);

  flock_scoreboard sb = new();
  int unsigned tx_idle_pct, rx_idle_pct;
  int unsigned cycles = 0;
  int unsigned cur_rad;   // larger of the two radii, whole pixels

  localparam int unsigned CYCLE_LIMIT = 4000000;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check at the edge where an item is taken, then pick next stall.
  always @(posedge clk_i) begin
    steer_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.fx = force_x_o; got.fy = force_y_o;
      got.close_n = close_count_o; got.near_n = near_count_o;
      sb.check_result(got);
    end
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // Write enable stays high across a burst; the caller drops it.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Drive one record; returns after the edge that accepts it.
  task automatic send_record(rec_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    self_x_i <= r.sx;  self_y_i <= r.sy;  self_vx_i <= r.svx; self_vy_i <= r.svy;
    nbr_x_i <= r.nx;   nbr_y_i <= r.ny;   nbr_vx_i <= r.nvx;  nbr_vy_i <= r.nvy;
    last_i <= r.last;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_record(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // let a finished run settle before the block is touched again
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_vel();
    int v;
    if ($urandom_range(9) < 3) return 16'($urandom);
    v = $urandom_range(2048) - 1024;
    return 16'(v);
  endfunction

  // Position of a neighbor near the boid, mostly inside the radius
  function automatic logic [15:0] near_pos(logic signed [15:0] self_p);
    int span, off, p;
    span = cur_rad * 16 * 5 / 4 + 4;
    off = $urandom_range(2 * span) - span;
    p = int'(self_p) + off;
    if (p > 32767 || p < -32768) p = int'(self_p) - off;
    return 16'(p);
  endfunction

  // One run of records; the final one carries the last flag.
  task automatic send_run(int unsigned len);
    rec_t r;
    logic signed [15:0] bx, by;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      int unsigned kind;
      kind = $urandom_range(9);
      r.sx = bx; r.sy = by; r.svx = rand_vel(); r.svy = rand_vel();
      r.nvx = rand_vel(); r.nvy = rand_vel();
      if (kind == 0) begin
        r.nx = bx; r.ny = by;                 // zero distance, skipped
      end else if (kind == 1) begin
        r.nx = 16'($urandom); r.ny = 16'($urandom);
      end else begin
        r.nx = near_pos(bx); r.ny = near_pos(by);
      end
      r.last = (i == len - 1);
      send_record(r);
    end
  endtask

  task automatic load_config(logic [15:0] spd, logic [15:0] frc, logic [11:0] ws,
                             logic [11:0] wa, logic [11:0] wc, logic [7:0] rs,
                             logic [7:0] rn);
    write_reg(CFG_MAX_SPEED, spd);
    write_reg(CFG_MAX_FORCE, frc);
    write_reg(CFG_SEP_W, ws);
    write_reg(CFG_ALI_W, wa);
    write_reg(CFG_COH_W, wc);
    write_reg(CFG_SEP_RAD, rs);
    write_reg(CFG_NBR_RAD, rn);
    cfg_we_i <= 1'b0;
    cur_rad = rs > rn ? rs : rn;
  endtask

  task automatic directed_records();
    rec_t r;
    // lone last record at zero distance: no neighbors at all
    r = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 1'b1};
    send_record(r);
    // extremes: farthest possible neighbor, then a close one with self position and velocities at the limits
    r = '{16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
          16'h8000, 16'h7fff, 1'b0};
    send_record(r);
    r = '{16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7ff0, 16'h7ff8,
          16'h7fff, 16'h8000, 1'b1};
    send_record(r);
    // very close neighbor (one LSB away) gives the largest repel term
    r = '{16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0101, 16'h0100,
          16'h0080, 16'h0000, 1'b0};
    send_record(r);
    r = '{16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h00ff,
          16'h0000, 16'hff80, 1'b1};
    send_record(r);
    // symmetric neighbors: repel sum and heading sum cancel to zero
    r = '{16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0020, 16'h0000,
          16'h0100, 16'h0000, 1'b0};
    send_record(r);
    r = '{16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'hffe0, 16'h0000,
          16'hff00, 16'h0000, 1'b1};
    send_record(r);
    // neighbor outside separation but inside neighbor radius
    r = '{16'h1000, 16'hf000, 16'h0040, 16'hffc0, 16'h1200, 16'hf000,
          16'h0200, 16'h0000, 1'b1};
    send_record(r);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; last_i = 1'b0;
    self_x_i = '0; self_y_i = '0; self_vx_i = '0; self_vy_i = '0;
    nbr_x_i = '0; nbr_y_i = '0; nbr_vx_i = '0; nbr_vy_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_MAX_SPEED; cfg_data_i = '0;
    tx_idle_pct = 37; rx_idle_pct = 85;
    cur_rad = RST_NBR_RAD;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset-value configuration first, with the directed records.
    directed_records();
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      int unsigned sent;
      tx_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 85 : 0;
      rx_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 37 : 0;
      case (ph)
        0: load_config(RST_MAX_SPEED, RST_MAX_FORCE, RST_SEP_W, RST_ALI_W, RST_COH_W,
                       RST_SEP_RAD, RST_NBR_RAD);
        1: load_config(16'hffff, 16'hffff, 12'hfff, 12'hfff, 12'hfff, 8'hff, 8'hff);
        2: load_config(16'h0000, 16'h0000, 12'h000, 12'h000, 12'h000, 8'h00, 8'h00);
        3: load_config(16'h0400, 16'h0100, 12'h155, 12'haaa, 12'h0ff, 8'd40, 8'd10);
        4: load_config(16'($urandom), 16'($urandom_range(2048)), 12'($urandom),
                       12'($urandom), 12'($urandom), 8'($urandom_range(1, 80)),
                       8'($urandom_range(1, 120)));
        default: load_config(16'h0200, 16'h8000, 12'h800, 12'h100, 12'h100, 8'd60, 8'd30);
      endcase
      if (ph == 0) begin
        // overlong run: records past the neighbor limit are dropped
        send_run(MAX_NEIGHBORS + 6);
        sent = MAX_NEIGHBORS + 6;
      end else begin
        sent = 0;
      end
      while (sent < 270) begin
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        send_run(len);
        sent += len;
        // hold off once until the block has delivered everything
        if (ph == 3 && sent >= 120 && sent < 120 + len) begin
          in_valid_i <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
      end
      wait_drained();
    end

    repeat (800) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bfs_pkg.sv
rtl/bfs_iter.sv
rtl/boid_flocking_steering_unit.sv
rtl/bfs_chk.sv
test/tb_top.sv
